/* rtl/text_console_writer_assert.svh */
// Assertion macros for the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

    localparam int ROWS_DEF  = 25;
    localparam int COLS_DEF  = 80;

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int CURSOR_W  = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 8;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0]  RESET_BLANK  = {COLOR_RESET, SPACE_CODE};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_BS    = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_INIT_WALK,
        S_INIT_DRAIN,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec_put;
        logic exec_bs;
        logic walk_start_scroll;
        logic walk_start_clear;
        logic walk_step;
        logic walk_copy;
        logic walk_init;
        logic respond;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic ch_zero;
        logic at_end;
        logic cur_zero;
        logic walk_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/tcw_ctrl.sv */
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_ctrl_t        ctrl,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_WALK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = S_INIT_DRAIN;
                end
            end
            S_INIT_DRAIN:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.cmd)
                    CMD_PUT:
                    begin
                        if (!status.ch_zero && status.at_end)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.cmd == CMD_PUT)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        case (state_reg)
            S_INIT_WALK:
            begin
                ctrl.walk_step = 1'b1;
                ctrl.walk_init = 1'b1;
            end
            S_INIT_DRAIN:
            begin
                busy = 1'b1;
            end
            S_IDLE:
            begin
                busy       = 1'b0;
                ctrl.latch = start;
            end
            S_EXEC:
            begin
                case (status.cmd)
                    CMD_PUT:
                    begin
                        if (status.ch_zero)
                        begin
                            ctrl.respond = 1'b1;
                        end
                        else if (status.at_end)
                        begin
                            ctrl.walk_start_scroll = 1'b1;
                        end
                        else
                        begin
                            ctrl.exec_put = 1'b1;
                            ctrl.respond  = 1'b1;
                        end
                    end
                    CMD_BS:
                    begin
                        ctrl.exec_bs = !status.cur_zero;
                        ctrl.respond = 1'b1;
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.walk_start_clear = 1'b1;
                    end
                    default:
                    begin
                        ctrl.respond = 1'b1;
                    end
                endcase
            end
            S_WALK:
            begin
                ctrl.walk_step = 1'b1;
                ctrl.walk_copy = (status.cmd == CMD_PUT);
            end
            S_DRAIN:
            begin
                ctrl.respond = (status.cmd != CMD_PUT);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tcw_datapath.sv */
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [CHAR_W-1:0]   char_code,
    input  wire logic [IDX_W-1:0]    cell_index,
    input  wire logic                cfg_we,
    input  wire logic [COLOR_W-1:0]  cfg_wdata,
    input  wire dp_ctrl_t            ctrl,
    output dp_status_t               status,
    output logic                     done,
    output logic [CURSOR_W-1:0]      cursor_pos,
    output logic [CELL_W-1:0]        cell_value,
    output logic                     did_scroll
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(NCELLS + 1);
    localparam int COLW   = $clog2(COLS);
    localparam int IW     = (CW > IDX_W) ? CW : IDX_W;

    logic [CELL_W-1:0]   cells_mem [NCELLS];

    logic [COLOR_W-1:0]  color_reg;
    cmd_t                cmd_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic                idx_ok_reg;
    logic [CW-1:0]       cursor_reg;
    logic [CW-1:0]       cursor_next;
    logic [COLW-1:0]     col_reg;
    logic [COLW-1:0]     col_next;
    logic                scrolled_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic                wr_v_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic                wr_copy_reg;
    logic                wr_init_reg;
    logic [CELL_W-1:0]   rdata_reg;
    logic                done_reg;
    logic [CURSOR_W-1:0] cursor_pos_reg;
    logic [CELL_W-1:0]   cell_value_reg;
    logic                did_scroll_reg;

    logic [IW-1:0]       idx_ext;
    logic                idx_ok;
    logic [IW-1:0]       cur_ext;
    logic [CW-1:0]       cur_dec;
    logic                ch_nl;
    logic                copy_ok;
    logic [AW-1:0]       walk_raddr;
    logic [CELL_W-1:0]   blank;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    assign idx_ext    = IW'(cell_index);
    assign idx_ok     = idx_ext < IW'(NCELLS);
    assign cur_dec    = cursor_reg - 1'b1;
    assign ch_nl      = (ch_reg == NEWLINE_CODE);
    assign copy_ok    = ptr_reg < AW'(NCELLS - COLS);
    assign walk_raddr = ptr_reg + AW'(COLS);
    assign blank      = {color_reg, SPACE_CODE};
    assign cur_ext    = IW'(cursor_next);

    assign status.cmd       = cmd_reg;
    assign status.ch_zero   = (ch_reg == '0);
    assign status.at_end    = (cursor_reg == CW'(NCELLS));
    assign status.cur_zero  = (cursor_reg == '0);
    assign status.walk_last = (ptr_reg == AW'(NCELLS - 1));

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (ctrl.walk_start_clear)
        begin
            cursor_next = '0;
            col_next    = '0;
        end
        else if (ctrl.walk_start_scroll)
        begin
            cursor_next = CW'(NCELLS - COLS);
            col_next    = '0;
        end
        else if (ctrl.exec_put)
        begin
            if (ch_nl)
            begin
                cursor_next = cursor_reg + CW'(COLS) - CW'(col_reg);
                col_next    = '0;
            end
            else
            begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == COLW'(COLS - 1)) ? '0 : col_reg + 1'b1;
            end
        end
        else if (ctrl.exec_bs)
        begin
            cursor_next = cur_dec;
            col_next    = (col_reg == '0) ? COLW'(COLS - 1) : col_reg - 1'b1;
        end
    end

    assign ptr_next = status.walk_last ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = blank;
        if (wr_v_reg)
        begin
            mem_we = 1'b1;
            if (wr_copy_reg)
            begin
                mem_wdata = rdata_reg;
            end
            else if (wr_init_reg)
            begin
                mem_wdata = RESET_BLANK;
            end
        end
        else if (ctrl.exec_put && !ch_nl)
        begin
            mem_we    = 1'b1;
            mem_waddr = cursor_reg[AW-1:0];
            mem_wdata = {color_reg, ch_reg};
        end
        else if (ctrl.exec_bs)
        begin
            mem_we    = 1'b1;
            mem_waddr = cur_dec[AW-1:0];
        end
    end

    assign rd_en   = (ctrl.latch && (cmd == CMD_READ) && idx_ok) ||
                     (ctrl.walk_step && ctrl.walk_copy && copy_ok);
    assign rd_addr = ctrl.walk_step ? walk_raddr : idx_ext[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= cells_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= COLOR_RESET;
            cursor_reg   <= '0;
            col_reg      <= '0;
            scrolled_reg <= 1'b0;
            ptr_reg      <= '0;
            wr_v_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            if (ctrl.latch)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (ctrl.walk_start_scroll)
            begin
                scrolled_reg <= 1'b1;
            end
            if (ctrl.walk_step)
            begin
                ptr_reg <= ptr_next;
            end
            wr_v_reg <= ctrl.walk_step;
            done_reg <= ctrl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg    <= cmd_t'(cmd);
            ch_reg     <= char_code;
            idx_ok_reg <= idx_ok;
        end
        wr_addr_reg <= ptr_reg;
        wr_copy_reg <= ctrl.walk_copy && copy_ok;
        wr_init_reg <= ctrl.walk_init;
        if (ctrl.respond)
        begin
            cursor_pos_reg <= cur_ext[CURSOR_W-1:0];
            cell_value_reg <= ((cmd_reg == CMD_READ) && idx_ok_reg) ? rdata_reg : '0;
            did_scroll_reg <= scrolled_reg;
        end
    end

    assign done       = done_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_value = cell_value_reg;
    assign did_scroll = did_scroll_reg;

endmodule

`default_nettype wire

/* rtl/text_console_writer.sv */
// Channel   | Signals                          | Handshake
// ----------+----------------------------------+-------------------------------
// request   | cmd, char_code, cell_index       | taken when start && !busy
// result    | cursor_pos, cell_value, did_scroll| done high for one cycle
// config    | cfg_wdata (text color)           | written when cfg_we is high
//
// Put, backspace, read and a null put return to idle from a single execute state.
// Clear and a put that scrolls keep busy high for a walk of every cell:
// the single write port of the cell memory is walked one cell per cycle.
// After reset a clearing pass runs with busy high.
// The result strobe cannot be stalled; it comes in the cycle busy returns low.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [CHAR_W-1:0]   char_code,
    input  wire logic [IDX_W-1:0]    cell_index,
    input  wire logic                cfg_we,
    input  wire logic [COLOR_W-1:0]  cfg_wdata,
    output logic                     done,
    output logic [CURSOR_W-1:0]      cursor_pos,
    output logic [CELL_W-1:0]        cell_value,
    output logic                     did_scroll
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .ctrl       (ctrl),
        .status     (status),
        .done       (done),
        .cursor_pos (cursor_pos),
        .cell_value (cell_value),
        .did_scroll (did_scroll)
    );

endmodule

`default_nettype wire

/* rtl/tcw_checker.sv */
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                done,
    input  wire logic [CURSOR_W-1:0] cursor_pos,
    input  wire logic [CELL_W-1:0]   cell_value,
    input  wire logic                did_scroll
);

    `TCW_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "result while busy")
    `TCW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after request")
    `TCW_ASSERT_NEXT(a_single_done, clk, rst_n, done, !done, "result strobe repeated")
    `TCW_ASSERT_SAME(a_cursor_range, clk, rst_n, done, int'(cursor_pos) <= ROWS * COLS, "cursor out of range")
    `TCW_ASSERT_SAME(a_scroll_no_value, clk, rst_n, done && did_scroll, cell_value == '0, "value on scroll")

endmodule

bind text_console_writer tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cell_value (cell_value),
    .did_scroll (did_scroll)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int NCELLS   = ROWS_DEF * COLS_DEF;
    localparam int WD_LIMIT = 20000;
    localparam int SEGMENTS = 6;
    localparam int SEG_REQS = 150;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   value;
        logic                scroll;
    } console_resp_t;

    typedef struct packed {
        cmd_t          op;
        logic [7:0]    ch;
        logic [10:0]   idx;
        logic [5:0]    reps;
        logic          typed;
        console_resp_t resp;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{CMD_READ,  8'h00,        11'd0,    6'd1,  1'b1, '{11'd0,    RESET_BLANK, 1'b0}},
        '{CMD_READ,  8'h00,        11'd2047, 6'd1,  1'b1, '{11'd0,    16'h0000,    1'b0}},
        '{CMD_BS,    8'h00,        11'd0,    6'd1,  1'b1, '{11'd0,    16'h0000,    1'b0}},
        '{CMD_PUT,   8'h00,        11'd0,    6'd1,  1'b1, '{11'd0,    16'h0000,    1'b0}},
        '{CMD_PUT,   8'hFF,        11'd0,    6'd1,  1'b1, '{11'd1,    16'h0000,    1'b0}},
        '{CMD_READ,  8'h00,        11'd0,    6'd1,  1'b1, '{11'd1,    16'h0FFF,    1'b0}},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    6'd1,  1'b1, '{11'd80,   16'h0000,    1'b0}},
        '{CMD_BS,    8'h00,        11'd0,    6'd1,  1'b1, '{11'd79,   16'h0000,    1'b0}},
        '{CMD_READ,  8'h00,        11'd79,   6'd1,  1'b1, '{11'd79,   RESET_BLANK, 1'b0}},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    6'd25, 1'b0, '0},
        '{CMD_PUT,   8'h00,        11'd0,    6'd1,  1'b1, '{11'd2000, 16'h0000,    1'b0}},
        '{CMD_READ,  8'h00,        11'd1999, 6'd1,  1'b1, '{11'd2000, RESET_BLANK, 1'b0}},
        '{CMD_READ,  8'h00,        11'd2000, 6'd1,  1'b1, '{11'd2000, 16'h0000,    1'b0}},
        '{CMD_PUT,   8'h5A,        11'd0,    6'd1,  1'b1, '{11'd1921, 16'h0000,    1'b1}},
        '{CMD_READ,  8'h00,        11'd1920, 6'd1,  1'b1, '{11'd1921, 16'h0F5A,    1'b0}},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    6'd1,  1'b1, '{11'd2000, 16'h0000,    1'b0}},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    6'd1,  1'b1, '{11'd2000, 16'h0000,    1'b1}},
        '{CMD_BS,    8'h00,        11'd0,    6'd1,  1'b1, '{11'd1999, 16'h0000,    1'b0}},
        '{CMD_READ,  8'h00,        11'd1920, 6'd1,  1'b1, '{11'd1999, RESET_BLANK, 1'b0}},
        '{CMD_READ,  8'h00,        11'd1840, 6'd1,  1'b1, '{11'd1999, 16'h0F5A,    1'b0}},
        '{CMD_CLEAR, 8'h00,        11'd0,    6'd1,  1'b1, '{11'd0,    16'h0000,    1'b0}},
        '{CMD_READ,  8'h00,        11'd1840, 6'd1,  1'b1, '{11'd0,    RESET_BLANK, 1'b0}}
    };

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [CMD_W-1:0]    cmd        = '0;
    logic [CHAR_W-1:0]   char_code  = '0;
    logic [IDX_W-1:0]    cell_index = '0;
    logic                cfg_we     = 1'b0;
    logic [COLOR_W-1:0]  cfg_wdata  = '0;
    logic                busy;
    logic                done;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_value;
    logic                did_scroll;

    logic [CELL_W-1:0]   screen_model [NCELLS];
    int                  cursor_model;
    logic [COLOR_W-1:0]  color_model;

    console_resp_t       expected_resps [$];
    console_resp_t       oldest_resp;
    int                  mismatch_count = 0;
    int                  send_idle_pct  = 31;
    int                  quiet_cycles   = 0;

    text_console_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .cursor_pos (cursor_pos),
        .cell_value (cell_value),
        .did_scroll (did_scroll)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic run_console_cmd(input cmd_t op, input logic [7:0] ch,
                                   input logic [10:0] idx, output console_resp_t resp);
        int i;
        resp = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch != 8'd0)
                begin
                    if (cursor_model >= NCELLS)
                    begin
                        for (i = 0; i < NCELLS - COLS_DEF; i++)
                            screen_model[i] = screen_model[i + COLS_DEF];
                        for (i = NCELLS - COLS_DEF; i < NCELLS; i++)
                            screen_model[i] = {color_model, SPACE_CODE};
                        cursor_model = NCELLS - COLS_DEF;
                        resp.scroll  = 1'b1;
                    end
                    if (ch == NEWLINE_CODE)
                        cursor_model = (cursor_model / COLS_DEF + 1) * COLS_DEF;
                    else
                    begin
                        screen_model[cursor_model] = {color_model, ch};
                        cursor_model++;
                    end
                end
            end
            CMD_BS:
            begin
                if (cursor_model > 0)
                begin
                    cursor_model--;
                    screen_model[cursor_model] = {color_model, SPACE_CODE};
                end
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < NCELLS; i++)
                    screen_model[i] = {color_model, SPACE_CODE};
                cursor_model = 0;
            end
            default:
            begin
                if (idx < NCELLS)
                    resp.value = screen_model[idx];
            end
        endcase
        resp.cursor = CURSOR_W'(cursor_model);
    endtask

    // start stays high from one request to the next unless the sender idles
    task automatic issue_request(input cmd_t op, input logic [7:0] ch, input logic [10:0] idx,
                                 input bit typed = 1'b0, input console_resp_t typed_resp = '0);
        console_resp_t predicted;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        start      <= 1'b1;
        cmd        <= op;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        run_console_cmd(op, ch, idx, predicted);
        expected_resps.push_back(typed ? typed_resp : predicted);
    endtask

    task automatic set_text_color(input logic [7:0] color);
        start <= 1'b0;
        while (expected_resps.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(posedge clk);
        cfg_we      <= 1'b0;
        color_model  = color;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                $display("%0t: unexpected result: cursor_pos %0d cell_value %h did_scroll %b",
                         $time, cursor_pos, cell_value, did_scroll);
                mismatch_count++;
            end
            else
            begin
                oldest_resp = expected_resps.pop_front();
                if (cursor_pos !== oldest_resp.cursor)
                begin
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $time, oldest_resp.cursor, cursor_pos);
                    mismatch_count++;
                end
                if (cell_value !== oldest_resp.value)
                begin
                    $display("%0t: cell_value expected %h actual %h",
                             $time, oldest_resp.value, cell_value);
                    mismatch_count++;
                end
                if (did_scroll !== oldest_resp.scroll)
                begin
                    $display("%0t: did_scroll expected %b actual %b",
                             $time, oldest_resp.scroll, did_scroll);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request nor a result taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time, expected_resps.size());
                $display("** text_console_writer: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int  seg;
        int  sent;
        int  pick;
        int  near;
        logic [7:0] ch;

        for (int i = 0; i < NCELLS; i++)
            screen_model[i] = RESET_BLANK;
        cursor_model = 0;
        color_model  = COLOR_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r])
            repeat (DIRECTED_ROWS[r].reps)
                issue_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].idx,
                              DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].resp);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 76 : 0;
            set_text_color((seg == 0) ? 8'h00 : (seg == 1) ? 8'hFF :
                           (seg == 4) ? COLOR_RESET : 8'($urandom_range(255)));
            sent = 0;
            while (sent < SEG_REQS)
            begin
                pick = $urandom_range(999);
                if (pick < 25)
                begin
                    // run of newlines to drive the cursor to the bottom and scroll
                    repeat ($urandom_range(30, 10))
                    begin
                        issue_request(CMD_PUT, NEWLINE_CODE, 11'($urandom_range(2047)));
                        sent++;
                    end
                end
                else if (pick < 30)
                begin
                    issue_request(CMD_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
                    sent++;
                end
                else if (pick < 630)
                begin
                    pick = $urandom_range(99);
                    ch = (pick < 20) ? NEWLINE_CODE : (pick < 23) ? 8'h00
                                                                : 8'($urandom_range(255));
                    issue_request(CMD_PUT, ch, 11'($urandom_range(2047)));
                    sent++;
                end
                else if (pick < 750)
                begin
                    issue_request(CMD_BS, 8'($urandom_range(255)), 11'($urandom_range(2047)));
                    sent++;
                end
                else
                begin
                    pick = $urandom_range(99);
                    near = cursor_model - int'($urandom_range(2));
                    if (near < 0)
                        near = 0;
                    if (pick < 45)
                        issue_request(CMD_READ, 8'($urandom_range(255)), 11'(near));
                    else if (pick < 90)
                        issue_request(CMD_READ, 8'($urandom_range(255)),
                                      11'($urandom_range(NCELLS - 1)));
                    else
                        issue_request(CMD_READ, 8'($urandom_range(255)),
                                      11'($urandom_range(2047, NCELLS)));
                    sent++;
                end
            end
        end

        start <= 1'b0;
        while (expected_resps.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        mismatch_count += expected_resps.size();
        if (mismatch_count == 0)
            $display("** text_console_writer: PASSED **");
        else
            $display("** text_console_writer: FAILED **");
        $finish;
    end

endmodule

/* text_console_writer.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/sv/tb_top.sv
